/* hw/rtl/dso_pkg.sv */
// ---------------------------------------------------------------------------
// dso_pkg
// Shared types and constants for the decaying shake oscillator.
// ---------------------------------------------------------------------------
package dso_pkg;

    localparam logic [1:0] CODE_TICK   = 2'd0;
    localparam logic [1:0] CODE_IMPACT = 2'd1;
    localparam logic [1:0] CODE_ROAR   = 2'd2;
    localparam logic [1:0] CODE_LIGHT  = 2'd3;

    localparam logic [2:0] REG_IMPACT_INT = 3'd0;
    localparam logic [2:0] REG_IMPACT_DUR = 3'd1;
    localparam logic [2:0] REG_ROAR_INT   = 3'd2;
    localparam logic [2:0] REG_ROAR_DUR   = 3'd3;
    localparam logic [2:0] REG_LIGHT_INT  = 3'd4;
    localparam logic [2:0] REG_LIGHT_DUR  = 3'd5;
    localparam logic [2:0] REG_FREQ       = 3'd6;
    localparam logic [2:0] REG_VSCALE     = 3'd7;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [31:0] MUL_Y = 32'd85197;
    localparam logic [31:0] MUL_Z = 32'd58982;
    localparam logic [22:0] ADD_Y = 23'd2803686;
    localparam logic [22:0] ADD_Z = 23'd5607371;
    localparam logic [31:0] SC1   = 32'd1686629713;
    localparam logic [31:0] SC3   = 32'd693598668;
    localparam logic [31:0] SC5   = 32'd85569306;
    localparam logic [31:0] SC7   = 32'd5026995;

    localparam int DIV_STEPS = 16;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_END,
        DP_TRIG,
        DP_TRIG_CMP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_MUL,
        DP_SAVE,
        DP_SETUP,
        DP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        M_ENV,
        M_STR,
        M_PHASE,
        M_TY,
        M_TZ,
        M_Z2,
        M_T7,
        M_T5,
        M_T3,
        M_S,
        M_AXM,
        M_VS
    } mul_t;

    typedef struct packed {
        dp_op_t     op;
        mul_t       mul;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic active;
        logic ended;
        logic preset_ok;
    } dp_status_t;

endpackage

/* hw/rtl/dso_ctrl.sv */
// ---------------------------------------------------------------------------
// dso_ctrl
// Sequencer: steps the datapath through divide, multiply and save commands.
// ---------------------------------------------------------------------------
module dso_ctrl
    import dso_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_INIT,
        S_DIV,
        S_MUL,
        S_SAVE,
        S_SETUP,
        S_TCMP,
        S_END,
        S_TRIG,
        S_DONE
    } state_t;

    state_t          state_reg;
    mul_t            mul_reg;
    logic [1:0]      axis_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic            out_valid_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op   = DP_NONE;
        cmd.mul  = mul_reg;
        cmd.axis = axis_reg;
        case (state_reg)
            S_IDLE:     cmd.op = in_valid ? DP_LOAD : DP_NONE;
            S_DIV_INIT: cmd.op = DP_DIV_INIT;
            S_DIV:      cmd.op = DP_DIV_STEP;
            S_MUL:      cmd.op = DP_MUL;
            S_SAVE:     cmd.op = DP_SAVE;
            S_SETUP:    cmd.op = DP_SETUP;
            S_TCMP:     cmd.op = DP_TRIG_CMP;
            S_END:      cmd.op = DP_END;
            S_TRIG:     cmd.op = DP_TRIG;
            S_DONE:     cmd.op = (!out_valid_reg || !out_stall) ? DP_OUT : DP_NONE;
            default:    cmd.op = DP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_reg       <= M_ENV;
            axis_reg      <= AXIS_X;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (status.is_tick)
                    begin
                        if (!status.active)
                            state_reg <= S_DONE;
                        else if (status.ended)
                            state_reg <= S_END;
                        else
                            state_reg <= S_DIV_INIT;
                    end
                    else
                    begin
                        if (!status.preset_ok)
                            state_reg <= S_DONE;
                        else if (!status.active)
                            state_reg <= S_TRIG;
                        else
                            state_reg <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        mul_reg   <= M_ENV;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_SAVE;
                end
                S_SAVE:
                begin
                    case (mul_reg)
                        M_ENV:
                        begin
                            mul_reg   <= M_STR;
                            state_reg <= S_MUL;
                        end
                        M_STR:
                        begin
                            if (status.is_tick)
                            begin
                                mul_reg   <= M_PHASE;
                                state_reg <= S_MUL;
                            end
                            else
                                state_reg <= S_TCMP;
                        end
                        M_PHASE:
                        begin
                            mul_reg   <= M_TY;
                            state_reg <= S_MUL;
                        end
                        M_TY:
                        begin
                            mul_reg   <= M_TZ;
                            state_reg <= S_MUL;
                        end
                        M_TZ:
                        begin
                            axis_reg  <= AXIS_X;
                            state_reg <= S_SETUP;
                        end
                        M_Z2:
                        begin
                            mul_reg   <= M_T7;
                            state_reg <= S_MUL;
                        end
                        M_T7:
                        begin
                            mul_reg   <= M_T5;
                            state_reg <= S_MUL;
                        end
                        M_T5:
                        begin
                            mul_reg   <= M_T3;
                            state_reg <= S_MUL;
                        end
                        M_T3:
                        begin
                            mul_reg   <= M_S;
                            state_reg <= S_MUL;
                        end
                        M_S:
                        begin
                            mul_reg   <= M_AXM;
                            state_reg <= S_MUL;
                        end
                        M_AXM, M_VS:
                        begin
                            if (mul_reg == M_AXM && axis_reg == AXIS_Y)
                            begin
                                mul_reg   <= M_VS;
                                state_reg <= S_MUL;
                            end
                            else if (axis_reg == AXIS_Z)
                                state_reg <= S_DONE;
                            else
                            begin
                                axis_reg  <= axis_reg + 1'b1;
                                state_reg <= S_SETUP;
                            end
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_SETUP:
                begin
                    mul_reg   <= M_Z2;
                    state_reg <= S_MUL;
                end
                S_TCMP, S_END, S_TRIG:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/dso_dp.sv */
// ---------------------------------------------------------------------------
// dso_dp
// Datapath: shake state, registers, restoring divider, shared multiplier.
// ---------------------------------------------------------------------------
module dso_dp
    import dso_pkg::*;
#(
    parameter int PHASE_BITS = 10,
    parameter int SINE_BITS  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         operation,
    input  logic [12:0]        delta_time,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic signed [16:0] offset_x,
    output logic signed [16:0] offset_y,
    output logic signed [16:0] offset_z,
    output logic               shaking
);

    localparam int QB = PHASE_BITS - 2;
    localparam int SW = SINE_BITS - 1;
    localparam logic [SW-1:0] LIM = {SW{1'b1}};

    logic [15:0] imp_int_reg, imp_dur_reg, roar_int_reg, roar_dur_reg;
    logic [15:0] light_int_reg, light_dur_reg, freq_reg;
    logic [12:0] vscale_reg;

    logic [15:0] amp_reg, len_reg, elapsed_reg;
    logic        active_reg;
    logic signed [16:0] held_x_reg, held_y_reg, held_z_reg;
    logic [1:0]  op_reg;

    logic [16:0] rem_reg;
    logic [15:0] quo_reg;
    logic [63:0] prod_reg;
    logic [16:0] env_reg;
    logic [15:0] str_reg;
    logic [31:0] p_reg;
    logic [22:0] ty_reg, tz_reg;
    logic [30:0] zf_reg, z2_reg;
    logic [31:0] t_reg;
    logic [1:0]  q_reg;
    logic [SW-1:0] s_reg;
    logic [15:0] m_reg;

    logic signed [16:0] out_x_reg, out_y_reg, out_z_reg;
    logic        out_act_reg;

    logic [15:0] inten, dur;
    logic [16:0] sum_dt;
    logic [17:0] r2;
    logic [16:0] om;
    logic [31:0] mul_a, mul_b;
    logic [22:0] turns;
    logic [PHASE_BITS-1:0] idx;
    logic [QB:0] r_q;
    logic [33:0] s_full, m_full, my_full;
    logic [15:0] m_sat, my_sat;
    logic        neg;

    assign offset_x = out_x_reg;
    assign offset_y = out_y_reg;
    assign offset_z = out_z_reg;
    assign shaking  = out_act_reg;

    always_comb
    begin
        case (op_reg)
            CODE_IMPACT: begin inten = imp_int_reg;   dur = imp_dur_reg;   end
            CODE_ROAR:   begin inten = roar_int_reg;  dur = roar_dur_reg;  end
            CODE_LIGHT:  begin inten = light_int_reg; dur = light_dur_reg; end
            default:     begin inten = 16'd0;         dur = 16'd0;         end
        endcase
    end

    assign status.is_tick   = (op_reg == CODE_TICK);
    assign status.active    = active_reg;
    assign status.ended     = (elapsed_reg >= len_reg);
    assign status.preset_ok = (inten != 16'd0) && (dur != 16'd0);

    assign sum_dt = {1'b0, elapsed_reg} + {4'd0, delta_time};
    assign r2     = {rem_reg, 1'b0};
    assign om     = 17'h10000 - {1'b0, quo_reg};

    always_comb
    begin
        case (cmd.axis)
            AXIS_Y:  turns = ty_reg;
            AXIS_Z:  turns = tz_reg;
            default: turns = p_reg[22:0];
        endcase
        idx = turns[22 -: PHASE_BITS];
        if (idx[QB])
            r_q = (QB+1)'(1 << QB) - {1'b0, idx[QB-1:0]};
        else
            r_q = {1'b0, idx[QB-1:0]};
    end

    always_comb
    begin
        case (cmd.mul)
            M_ENV:   begin mul_a = 32'(om);          mul_b = 32'(om);          end
            M_STR:   begin mul_a = 32'(amp_reg);     mul_b = 32'(env_reg);     end
            M_PHASE: begin mul_a = 32'(elapsed_reg); mul_b = 32'(freq_reg);    end
            M_TY:    begin mul_a = p_reg;            mul_b = MUL_Y;            end
            M_TZ:    begin mul_a = p_reg;            mul_b = MUL_Z;            end
            M_Z2:    begin mul_a = 32'(zf_reg);      mul_b = 32'(zf_reg);      end
            M_T7:    begin mul_a = SC7;              mul_b = 32'(z2_reg);      end
            M_T5:    begin mul_a = t_reg;            mul_b = 32'(z2_reg);      end
            M_T3:    begin mul_a = t_reg;            mul_b = 32'(z2_reg);      end
            M_S:     begin mul_a = t_reg;            mul_b = 32'(zf_reg);      end
            M_AXM:   begin mul_a = 32'(s_reg);       mul_b = 32'(str_reg);     end
            M_VS:    begin mul_a = 32'(m_reg);       mul_b = 32'(vscale_reg);  end
            default: begin mul_a = 32'd0;            mul_b = 32'd0;            end
        endcase
    end

    assign s_full  = 34'(prod_reg >> (61 - SINE_BITS));
    assign m_full  = 34'(prod_reg >> (SINE_BITS - 1));
    assign my_full = 34'(prod_reg >> 12);
    assign m_sat   = (|m_full[33:16]) ? 16'hFFFF : m_full[15:0];
    assign my_sat  = (|my_full[33:16]) ? 16'hFFFF : my_full[15:0];
    assign neg     = q_reg[1] && (s_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imp_int_reg   <= '0;
            imp_dur_reg   <= '0;
            roar_int_reg  <= '0;
            roar_dur_reg  <= '0;
            light_int_reg <= '0;
            light_dur_reg <= '0;
            freq_reg      <= '0;
            vscale_reg    <= '0;
            amp_reg       <= '0;
            len_reg       <= '0;
            elapsed_reg   <= '0;
            active_reg    <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            held_z_reg    <= '0;
            op_reg        <= CODE_TICK;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_IMPACT_INT: imp_int_reg   <= cfg_data;
                    REG_IMPACT_DUR: imp_dur_reg   <= cfg_data;
                    REG_ROAR_INT:   roar_int_reg  <= cfg_data;
                    REG_ROAR_DUR:   roar_dur_reg  <= cfg_data;
                    REG_LIGHT_INT:  light_int_reg <= cfg_data;
                    REG_LIGHT_DUR:  light_dur_reg <= cfg_data;
                    REG_FREQ:       freq_reg      <= cfg_data;
                    REG_VSCALE:     vscale_reg    <= cfg_data[12:0];
                    default:        freq_reg      <= freq_reg;
                endcase
            end
            case (cmd.op)
                DP_LOAD:
                begin
                    op_reg <= operation;
                    if (operation == CODE_TICK && active_reg)
                        elapsed_reg <= sum_dt[16] ? 16'hFFFF : sum_dt[15:0];
                end
                DP_END:
                begin
                    active_reg <= 1'b0;
                    held_x_reg <= '0;
                    held_y_reg <= '0;
                    held_z_reg <= '0;
                end
                DP_TRIG, DP_TRIG_CMP:
                begin
                    if (cmd.op == DP_TRIG || inten >= str_reg)
                    begin
                        amp_reg     <= inten;
                        len_reg     <= dur;
                        elapsed_reg <= '0;
                        active_reg  <= 1'b1;
                    end
                end
                DP_SAVE:
                begin
                    if (cmd.mul == M_AXM && cmd.axis == AXIS_X)
                        held_x_reg <= neg ? -$signed({1'b0, m_sat}) : $signed({1'b0, m_sat});
                    if (cmd.mul == M_AXM && cmd.axis == AXIS_Z)
                        held_z_reg <= neg ? -$signed({1'b0, m_sat}) : $signed({1'b0, m_sat});
                    if (cmd.mul == M_VS)
                        held_y_reg <= (neg && my_sat != 16'd0) ? -$signed({1'b0, my_sat})
                                                               : $signed({1'b0, my_sat});
                end
                default: op_reg <= op_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_DIV_INIT:
            begin
                rem_reg <= {1'b0, elapsed_reg};
                quo_reg <= '0;
            end
            DP_DIV_STEP:
            begin
                if (r2 >= {2'b00, len_reg})
                begin
                    rem_reg <= 17'(r2 - {2'b00, len_reg});
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2[16:0];
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
            end
            DP_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            DP_SETUP:
            begin
                zf_reg <= {r_q, {(30 - QB){1'b0}}};
                q_reg  <= idx[PHASE_BITS-1 -: 2];
            end
            DP_SAVE:
            begin
                case (cmd.mul)
                    M_ENV:   env_reg <= prod_reg[32:16];
                    M_STR:   str_reg <= prod_reg[31:16];
                    M_PHASE: p_reg   <= prod_reg[31:0];
                    M_TY:    ty_reg  <= prod_reg[38:16] + ADD_Y;
                    M_TZ:    tz_reg  <= prod_reg[38:16] + ADD_Z;
                    M_Z2:    z2_reg  <= prod_reg[60:30];
                    M_T7:    t_reg   <= SC5 - prod_reg[61:30];
                    M_T5:    t_reg   <= SC3 - prod_reg[61:30];
                    M_T3:    t_reg   <= SC1 - prod_reg[61:30];
                    M_S:     s_reg   <= (s_full > 34'(LIM)) ? LIM : s_full[SW-1:0];
                    M_AXM:   m_reg   <= m_sat;
                    default: m_reg   <= m_reg;
                endcase
            end
            DP_OUT:
            begin
                out_x_reg   <= held_x_reg;
                out_y_reg   <= held_y_reg;
                out_z_reg   <= held_z_reg;
                out_act_reg <= active_reg;
            end
            default: prod_reg <= prod_reg;
        endcase
    end

endmodule

/* hw/rtl/decaying_shake_oscillator_core.sv */
// ---------------------------------------------------------------------------
// decaying_shake_oscillator_core
// Three-axis decaying shake generator driven by tick and trigger requests.
// ---------------------------------------------------------------------------
// One result per request. A tick while idle, or one that ends the shake, and
// any trigger on an idle block skip the arithmetic; a trigger on a live
// shake and an active tick run the 16-step restoring divider for t/d and
// the single shared 32x32 multiplier that runs the envelope, phase and
// three sine polynomials one product at a time. A finished result waits
// in the output register while the next request is taken.
module decaying_shake_oscillator_core
    import dso_pkg::*;
#(
    parameter int PHASE_BITS = 10,
    parameter int SINE_BITS  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [12:0]        delta_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] offset_x,
    output logic signed [16:0] offset_y,
    output logic signed [16:0] offset_z,
    output logic               shaking
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    dso_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dso_dp #(
        .PHASE_BITS (PHASE_BITS),
        .SINE_BITS  (SINE_BITS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .operation  (operation),
        .delta_time (delta_time),
        .cmd        (cmd),
        .status     (status),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .offset_z   (offset_z),
        .shaking    (shaking)
    );

endmodule
